[sv/hte_pkg.sv]
// shared types and constants for the huffman table encoder
// used by hte_byte_drain and huffman_table_encoder; no dependencies

package hte_pkg;

  // table geometry
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int SYM_AW       = $clog2(SYMBOL_COUNT);

  // field and datapath widths
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int CNT_W   = 3;
  localparam int ACC_W   = PEND_W + WORD_W;
  localparam int ALIGN_W = ACC_W + 1;
  localparam int TOT_W   = 6;

  // bytes one encode can complete: seven pending bits plus the longest code
  localparam int MAX_BYTES = (PEND_W + LEN_LIMIT) / BYTE_W;
  localparam int IDX_W     = 2;

  // group queue between packer and byte output
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = FIFO_AW + 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // bytes completed by one item, byte 0 goes out first
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } group_push_t;

endpackage

[sv/hte_byte_drain.sv]
// group queue and byte serializer for the huffman table encoder
// depends on hte_pkg

module hte_byte_drain import hte_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  group_push_t         push,
  output logic [FILL_W-1:0]   fill,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                last_of_run
);

  group_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [IDX_W-1:0]   sub_idx;
  group_t             head;
  logic               out_take;
  logic               pop;

  assign head        = fifo_mem[rd_ptr];
  assign out_valid   = (fill != '0);
  assign out_byte    = head.bytes[sub_idx];
  assign last_of_run = (sub_idx == head.last_idx);
  assign out_take    = out_valid && !out_stall;
  assign pop         = out_take && last_of_run;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      fifo_mem[wr_ptr] <= push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      sub_idx <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill <= fill + FILL_W'(push.valid) - FILL_W'(pop);
      if (out_take) begin
        sub_idx <= last_of_run ? '0 : sub_idx + IDX_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (fill < FILL_W'(FIFO_DEPTH)))
    else $error("group queue overflow");

  a_sub_in_group: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sub_idx <= head.last_idx))
    else $error("byte index past end of group");

  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (sub_idx == '0))
    else $error("byte index not cleared while queue empty");

endmodule

[sv/huffman_table_encoder.sv]
// huffman table encoder top level: code table memory, bit packer, byte output
// depends on hte_pkg and hte_byte_drain
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  opcode, symbol, code_bits, code_length
//  output    out        out_valid / out_stall out_byte, last_of_run
//
// one input word per cycle while in_stall is low: the table read is registered, the packer
//   finishes the item from it, and its group passes through the queue before a byte can leave
// output runs at one byte per cycle while the queue holds a group and out_stall is low;
//   an encode yields 0 to 4 bytes, a flush 1; an 8-entry group queue sits between packer
//   and output; in_stall rises when the queue plus the item in the packer stage would fill it
// reset clears the per-entry length valid flags at once, no clearing pass needed
// out_stall only backs up the queue; the packer never stalls mid-item

module huffman_table_encoder import hte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         symbol,
  input  logic [WORD_W-1:0]  code_bits,
  input  logic [LEN_W-1:0]   code_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last_of_run
);

  // code table: word and length per symbol, synchronous read
  entry_t                  tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tbl_valid;
  entry_t                  rd_entry;
  logic                    rd_valid;

  logic                    in_accept;
  logic                    sym_in_range;
  logic [SYM_AW-1:0]       tbl_addr;
  logic [LEN_W-1:0]        len_sat;
  logic [WORD_W:0]         len_mask;
  logic                    tbl_wr;

  // packer stage registers
  logic                    s1_valid;
  logic [1:0]              s1_op;
  logic                    s1_in_range;

  // pending partial byte, right aligned, oldest bit highest
  logic [PEND_W-1:0]       pending_bits;
  logic [PEND_W-1:0]       pending_bits_next;
  logic [CNT_W-1:0]        pending_count;
  logic [CNT_W-1:0]        pending_count_next;

  // packer datapath
  logic [LEN_W-1:0]        len_eff;
  logic [ACC_W-1:0]        acc;
  logic [TOT_W-1:0]        total;
  logic [ALIGN_W-1:0]      aligned;
  logic [2:0]              n_bytes;
  logic [BYTE_W-1:0]       rem_mask;
  logic [3:0]              fl_total;
  logic [BYTE_W-1:0]       fl_byte;
  group_t                  enc_grp;
  group_t                  fl_grp;
  group_push_t             push;
  logic [FILL_W-1:0]       fill;

  assign in_accept    = in_valid && !in_stall;
  assign sym_in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
  assign tbl_addr     = symbol[SYM_AW-1:0];

  // saturate the length and drop code bits above it before they are stored
  assign len_sat  = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
  assign len_mask = ((WORD_W+1)'(1) << len_sat) - (WORD_W+1)'(1);
  assign tbl_wr   = in_accept && (opcode == OP_LOAD) && sym_in_range;

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      tbl_mem[tbl_addr] <= '{word: code_bits & len_mask[WORD_W-1:0], len: len_sat};
    end
    rd_entry <= tbl_mem[tbl_addr];
    rd_valid <= tbl_valid[tbl_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid     <= '0;
      s1_valid      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (tbl_wr) begin
        tbl_valid[tbl_addr] <= 1'b1;
      end
      s1_valid      <= in_accept;
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_op       <= opcode;
    s1_in_range <= sym_in_range;
  end

  // an entry never loaded reads as length zero
  assign len_eff = (s1_in_range && rd_valid) ? rd_entry.len : '0;
  assign acc     = (ACC_W'(pending_bits) << len_eff) | ACC_W'(rd_entry.word);
  assign total   = TOT_W'(pending_count) + TOT_W'(len_eff);

  // move the earliest valid bit to the top so bytes come off in fixed slots
  assign aligned  = ALIGN_W'(acc) << (TOT_W'(ALIGN_W) - total);
  assign n_bytes  = total[TOT_W-1:3];
  assign rem_mask = (BYTE_W'(1) << total[2:0]) - BYTE_W'(1);

  // flush: marker bit after the pending bits, zero fill below
  assign fl_total = 4'(pending_count) + 4'd1;
  assign fl_byte  = {pending_bits, 1'b1} << (4'd8 - fl_total);

  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      enc_grp.bytes[k] = aligned[ALIGN_W-1-BYTE_W*k -: BYTE_W];
    end
    enc_grp.last_idx = IDX_W'(n_bytes - 3'd1);

    fl_grp          = '0;
    fl_grp.bytes[0] = fl_byte;
  end

  always_comb begin
    push               = '0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (s1_valid) begin
      case (opcode_t'(s1_op))
        OP_ENCODE: begin
          if (len_eff != '0) begin
            pending_bits_next  = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
            pending_count_next = total[CNT_W-1:0];
            if (n_bytes != '0) begin
              push.valid = 1'b1;
              push.grp   = enc_grp;
            end
          end
        end
        OP_FLUSH: begin
          push.valid         = 1'b1;
          push.grp           = fl_grp;
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // hold off input while the queue could not take the packer's group
  assign in_stall = (({1'b0, fill}) + (FILL_W+1)'(s1_valid)) >= (FILL_W+1)'(FIFO_DEPTH);

  hte_byte_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .fill        (fill),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending_bits >> pending_count) == '0)
    else $error("stale bits above pending count");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_op == OP_FLUSH)) |=> (pending_count == '0))
    else $error("flush left pending bits");

  a_load_marks: assert property (@(posedge clk) disable iff (rst)
    tbl_wr |=> tbl_valid[$past(tbl_addr)])
    else $error("loaded entry not marked valid");

endmodule

[tb/sv/huffman_table_encoder_tb.sv]
// self-checking testbench for huffman_table_encoder: code table loads, encodes, flushes
// depends on hte_pkg and the huffman_table_encoder rtl
`timescale 1ns / 1ps

module huffman_table_encoder_tb;
  import hte_pkg::*;

  // opcode 3 has no meaning in the block, it must be dropped silently
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one input word as the sender sees it
  typedef struct {
    logic [1:0]        op;
    logic [7:0]        sym;
    logic [WORD_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    bit                drain_first;  // hold this word back until all bytes are out
  } enc_word_t;

  // receiver stall patterns
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        opcode = '0;
  logic [7:0]        symbol = '0;
  logic [WORD_W-1:0] code_bits = '0;
  logic [LEN_W-1:0]  code_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  huffman_table_encoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted encoder state: code table plus the partial byte
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] tbl_word [SYMBOL_COUNT];
  logic [LEN_W-1:0]  tbl_len  [SYMBOL_COUNT];
  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_cnt;

  // packed bytes still owed by the block, oldest first
  logic [BYTE_W-1:0] exp_byte_q [$];
  logic              exp_last_q [$];

  // words waiting to be offered to the block
  enc_word_t         stim_q [$];

  int errors = 0;

  // applies one accepted word to the predicted state, queues the bytes it completes
  task automatic pack_code(input enc_word_t w);
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  n;
    logic [BYTE_W-1:0] b;
    int                total;
    int                made;
    case (w.op)
      OP_LOAD: begin
        // lengths beyond the table limit saturate, extra code bits are don't care
        n = (w.len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : w.len;
        if (int'(w.sym) < SYMBOL_COUNT) begin
          tbl_len[w.sym]  = n;
          tbl_word[w.sym] = w.bits;
        end
      end
      OP_ENCODE: begin
        if (int'(w.sym) < SYMBOL_COUNT && tbl_len[w.sym] != '0) begin
          n     = tbl_len[w.sym];
          acc   = (ACC_W'(pend_bits) << n)
                | (ACC_W'(tbl_word[w.sym]) & ((ACC_W'(1) << n) - ACC_W'(1)));
          total = int'(pend_cnt) + int'(n);
          made  = 0;
          // peel off complete bytes, earliest bit first
          while (total >= BYTE_W) begin
            total -= BYTE_W;
            b = BYTE_W'(acc >> total);
            exp_byte_q.push_back(b);
            exp_last_q.push_back(1'b0);
            made++;
          end
          if (made > 0)
            exp_last_q[exp_last_q.size()-1] = 1'b1;
          pend_bits = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
          pend_cnt  = CNT_W'(total);
        end
      end
      OP_FLUSH: begin
        // marker bit right after the pending bits, zeros behind it
        b = BYTE_W'({pend_bits, 1'b1} << (7 - int'(pend_cnt)));
        exp_byte_q.push_back(b);
        exp_last_q.push_back(1'b1);
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of words with random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  enc_word_t cur_word;
  int        burst_left;
  int        gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      opcode      <= '0;
      symbol      <= '0;
      code_bits   <= '0;
      code_length <= '0;
      burst_left  = $urandom_range(1, 16);
      gap_left    = 0;
      pend_bits   = '0;
      pend_cnt    = '0;
      foreach (tbl_len[i]) tbl_len[i] = '0;
      foreach (tbl_word[i]) tbl_word[i] = '0;
    end else begin
      // word taken at this edge: update the prediction
      if (in_valid && !in_stall)
        pack_code(cur_word);
      // a new word may go out only when the bus is free
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0 &&
                     (!stim_q[0].drain_first || exp_byte_q.size() == 0)) begin
          cur_word = stim_q.pop_front();
          in_valid    <= 1'b1;
          opcode      <= cur_word.op;
          symbol      <= cur_word.sym;
          code_bits   <= cur_word.bits;
          code_length <= cur_word.len;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // about a third of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall: changing patterns plus one long hold to back up the block
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode;
  int       rx_phase_left;
  int       hold_left;
  bit       hold_done;
  int       bytes_seen;

  always @(posedge clk) begin
    if (rst) begin
      out_stall     <= 1'b0;
      rx_mode       = RX_FREE;
      rx_phase_left = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
      bytes_seen    = 0;
    end else begin
      if (out_valid && !out_stall)
        bytes_seen++;
      // once the random traffic is flowing, refuse everything for a long stretch
      if (!hold_done && bytes_seen >= 40) begin
        hold_left = 150;
        hold_done = 1'b1;
      end
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(8, 40);
      end
      rx_phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= !out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every byte taken is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] want_byte;
  logic              want_last;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (exp_byte_q.size() == 0) begin
        $error("unexpected output word: out_byte=%02h last_of_run=%0b", out_byte, last_of_run);
        errors++;
      end else begin
        want_byte = exp_byte_q.pop_front();
        want_last = exp_last_q.pop_front();
        if (out_byte !== want_byte) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want_byte, out_byte);
          errors++;
        end
        if (last_of_run !== want_last) begin
          $error("last_of_run mismatch: expected %0b, actual %0b", want_last, last_of_run);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] op, input logic [7:0] sym,
                           input logic [WORD_W-1:0] bits, input logic [LEN_W-1:0] len,
                           input bit drain_first);
    enc_word_t w;
    w.op          = op;
    w.sym         = sym;
    w.bits        = bits;
    w.len         = len;
    w.drain_first = drain_first;
    stim_q.push_back(w);
  endtask

  // mostly short codes, some long, some overlong, some unused
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)      return '0;
    else if (r == 1) return LEN_W'($urandom_range(33, 63));
    else if (r == 2) return LEN_W'($urandom_range(17, 32));
    else             return LEN_W'($urandom_range(1, 10));
  endfunction

  initial begin : stimulus
    logic [7:0]       live_syms [$];
    logic [7:0]       s;
    logic [LEN_W-1:0] l;
    int               taken;
    int               r;

    // directed: empty entry, bare flush, length extremes, marker placement
    push_word(OP_ENCODE, 8'h05, '0, '0, 1'b0);                // never loaded: no bytes
    push_word(OP_FLUSH,  8'h00, '0, '0, 1'b0);                // nothing pending: 0x80
    push_word(OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0);  // longest code
    push_word(OP_LOAD,   8'hFF, 32'h0000_0000, 6'd1,  1'b0);  // single zero bit
    push_word(OP_LOAD,   8'h01, 32'hA5A5_A5A5, 6'd63, 1'b0);  // overlong, saturates
    push_word(OP_LOAD,   8'h02, 32'h5A5A_5A5A, 6'd3,  1'b0);  // upper bits ignored
    push_word(OP_LOAD,   8'h03, 32'h1234_5678, 6'd0,  1'b0);  // marked unused
    push_word(OP_LOAD,   8'h04, 32'h0000_00FF, 6'd7,  1'b0);
    push_word(OP_LOAD,   8'h06, 32'hDEAD_BEEF, 6'd33, 1'b0);  // just past the limit
    push_word(OP_ENCODE, 8'h00, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'hFF, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'h01, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'h02, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'h03, '0, '0, 1'b0);                // zero length entry
    push_word(OP_UNUSED, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0);  // dropped
    push_word(OP_FLUSH,  8'h00, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'h02, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'h02, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'hFF, '0, '0, 1'b0);                // seven bits pending
    push_word(OP_FLUSH,  8'h00, '0, '0, 1'b0);                // marker lands in bit 0
    push_word(OP_ENCODE, 8'h04, '0, '0, 1'b0);
    push_word(OP_ENCODE, 8'h06, '0, '0, 1'b0);                // 7 + 32 bits: four bytes
    push_word(OP_FLUSH,  8'h00, '0, '0, 1'b0);

    // random: fill part of the table, then mostly encodes of loaded symbols
    taken = 0;
    while (taken < 40) begin
      s = 8'($urandom_range(0, SYMBOL_COUNT - 1));
      l = pick_len();
      push_word(OP_LOAD, s, $urandom, l, taken == 0);
      if (l != '0)
        live_syms.push_back(s);
      taken++;
    end
    while (taken < 130) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        push_word(OP_ENCODE, live_syms[$urandom_range(0, live_syms.size() - 1)],
                  $urandom, LEN_W'($urandom), 1'b0);
        taken++;
      end else if (r < 70) begin
        push_word(OP_ENCODE, 8'($urandom), $urandom, LEN_W'($urandom), 1'b0);
        taken++;
      end else if (r < 79) begin
        push_word(OP_FLUSH, 8'($urandom), $urandom, LEN_W'($urandom), 1'b0);
        taken++;
      end else if (r < 90) begin
        // reload: the entry changes while earlier codes may still be draining
        s = ($urandom_range(0, 1) == 0) ? live_syms[$urandom_range(0, live_syms.size() - 1)]
                                         : 8'($urandom);
        l = pick_len();
        push_word(OP_LOAD, s, $urandom, l, 1'b0);
        if (l != '0)
          live_syms.push_back(s);
        taken++;
      end else if (r < 95) begin
        push_word(OP_UNUSED, 8'($urandom), $urandom, LEN_W'($urandom), 1'b0);
      end else begin
        // sender waits until the block has emptied before this one
        push_word(OP_ENCODE, live_syms[$urandom_range(0, live_syms.size() - 1)],
                  $urandom, LEN_W'($urandom), 1'b1);
        taken++;
      end
    end
    push_word(OP_FLUSH, 8'h00, '0, '0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // all words handed over, then all bytes back, then a short settle
    do @(posedge clk); while (stim_q.size() != 0 || in_valid);
    while (exp_byte_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/hte_pkg.sv
sv/hte_byte_drain.sv
sv/huffman_table_encoder.sv
tb/sv/huffman_table_encoder_tb.sv
